/* design/ipv4bl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4bl_pkg
// shared types and constants of the ipv4 source blocklist filter
// ----------------------------------------------------------------------------
package ipv4bl_pkg;

   localparam int TableEntriesDefault = 1024;
   localparam int MaxTagsDefault      = 2;

   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

   localparam logic [15:0] TYPE_IPV4  = 16'h0800;
   localparam logic [15:0] TYPE_TAG_A = 16'h8100;
   localparam logic [15:0] TYPE_TAG_B = 16'h88A8;
   localparam logic [15:0] TYPE_TAG_C = 16'h9100;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [6:0]  OFFSET_MAX = 7'd127;
   localparam logic [6:0]  ETH_HDR_LEN = 7'd14;
   localparam logic [6:0]  IPV4_MIN_LEN = 7'd20;
   localparam logic [15:0] BYPASS_PORT_RESET = 16'd22;

   // csr register indexes
   localparam logic [0:0] CSR_BYPASS_ENABLE = 1'b0;
   localparam logic [0:0] CSR_BYPASS_PORT   = 1'b1;

   // frame summary handed from parser to the table engine
   typedef struct packed {
      logic        ipv4_ok;    // ipv4 and minimal 20-byte header present
      logic        exempt;     // bypass conditions met
      logic [31:0] source;
   } frame_info_type;

endpackage

/* design/ipv4bl_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4bl_parser
// byte-wise ethernet / tag / ipv4 header parser
// ----------------------------------------------------------------------------
module ipv4bl_parser
   import ipv4bl_pkg::*;
#(
   parameter int MAX_TAGS = MaxTagsDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   input  logic           bypass_enable,
   input  logic [15:0]    bypass_port,
   output frame_info_type info
);

   logic [6:0]  offset_ff, offset_in;
   logic [15:0] type_ff, type_in;
   logic [1:0]  tags_ff, tags_in;
   logic [6:0]  hstart_ff, hstart_in;
   logic [3:0]  words_ff, words_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [15:0] dport_ff, dport_in;
   logic        ipv4_ff, ipv4_in;

   logic [6:0] rel, port_at;
   logic [7:0] len, ihl_bytes;
   logic       is_tag;

   always_comb begin
      offset_in = offset_ff;
      type_in   = type_ff;
      tags_in   = tags_ff;
      hstart_in = hstart_ff;
      words_in  = words_ff;
      proto_in  = proto_ff;
      src_in    = src_ff;
      dport_in  = dport_ff;
      ipv4_in   = ipv4_ff;
      rel       = offset_ff - hstart_ff;
      port_at   = {1'b0, words_ff, 2'b10};
      is_tag    = 1'b0;
      if (offset_ff < hstart_ff) begin
         type_in = {type_ff[7:0], data_byte};
         is_tag  = (type_in == TYPE_TAG_A) || (type_in == TYPE_TAG_B) ||
                   (type_in == TYPE_TAG_C);
         if (offset_ff == hstart_ff - 7'd1) begin
            if (is_tag && (32'(tags_ff) < MAX_TAGS)) begin
               tags_in   = tags_ff + 2'd1;
               hstart_in = hstart_ff + 7'd4;
            end else begin
               ipv4_in = (type_in == TYPE_IPV4);
            end
         end
      end else if (ipv4_ff) begin
         if (rel == 7'd0) words_in = data_byte[3:0];
         else if (rel == 7'd9) proto_in = data_byte;
         else if (rel >= 7'd12 && rel <= 7'd15) src_in = {src_ff[23:0], data_byte};
         if (rel == port_at) dport_in = {data_byte, dport_ff[7:0]};
         else if (rel == port_at + 7'd1) dport_in = {dport_ff[15:8], data_byte};
      end
      if (offset_ff < OFFSET_MAX) offset_in = offset_ff + 7'd1;
   end

   // verdict terms use the updated fields of the last byte
   always_comb begin
      len       = {1'b0, offset_ff} + 8'd1;
      ihl_bytes = {2'b00, words_in, 2'b00};
      info.source  = src_in;
      info.ipv4_ok = ipv4_in && (len >= {1'b0, hstart_in} + {1'b0, IPV4_MIN_LEN});
      info.exempt  = bypass_enable && (proto_in == PROTO_TCP) &&
                     (ihl_bytes >= 8'd20) && (ihl_bytes <= 8'd60) &&
                     ({1'b0, len} >= {2'b00, hstart_in} + {1'b0, ihl_bytes} + 9'd4) &&
                     (dport_in == bypass_port);
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         offset_ff <= '0;
         type_ff   <= '0;
         tags_ff   <= '0;
         hstart_ff <= ETH_HDR_LEN;
         words_ff  <= '0;
         proto_ff  <= '0;
         src_ff    <= '0;
         dport_ff  <= '0;
         ipv4_ff   <= 1'b0;
      end else if (take) begin
         offset_ff <= offset_in;
         type_ff   <= type_in;
         tags_ff   <= tags_in;
         hstart_ff <= hstart_in;
         words_ff  <= words_in;
         proto_ff  <= proto_in;
         src_ff    <= src_in;
         dport_ff  <= dport_in;
         ipv4_ff   <= ipv4_in;
      end
   end

endmodule

/* design/ipv4bl_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4bl_table
// blocklist set: address, counter and valid memories with a sequential scan engine
// ----------------------------------------------------------------------------
module ipv4bl_table
   import ipv4bl_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     kind,
   input  logic [31:0]    address,
   input  frame_info_type info,
   output logic           busy,
   output logic           done,
   output logic           verdict,
   output logic [1:0]     status,
   output logic [63:0]    drop_total
);

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);
   localparam int Last = TABLE_ENTRIES - 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] addr_mem  [TABLE_ENTRIES];
   logic [63:0] drop_mem  [TABLE_ENTRIES];
   logic        valid_mem [TABLE_ENTRIES];

   logic [CntW-1:0] scan_ff, scan_in;      // address under read
   logic [IdxW-1:0] hit_ff, hit_in, free_ff, free_in, chk_ff;
   logic            found_ff, found_in, has_free_ff, has_free_in;
   logic [1:0]      kind_ff;
   logic [31:0]     key_ff;
   logic            exempt_ff, skip_ff;
   logic            done_ff, verdict_ff;
   logic [1:0]      status_ff;
   logic [63:0]     total_ff;
   logic [31:0]     rd_addr_ff;
   logic [63:0]     rd_drop_ff;
   logic            chk_valid_ff;
   logic            addr_we, drop_we;
   logic [IdxW-1:0] wr_idx;
   logic [63:0]     drop_wdata;
   logic            valid_we, valid_wdata;
   logic [IdxW-1:0] valid_widx;

   // registered memory reads
   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_mem[scan_ff[IdxW-1:0]];
      rd_drop_ff <= drop_mem[hit_ff];
      chk_ff     <= scan_ff[IdxW-1:0];
      chk_valid_ff <= valid_mem[scan_ff[IdxW-1:0]];
      if (addr_we) addr_mem[wr_idx] <= key_ff;
      if (drop_we) drop_mem[wr_idx] <= drop_wdata;
      if (valid_we) valid_mem[valid_widx] <= valid_wdata;
   end

   logic match;
   assign match = chk_valid_ff && (rd_addr_ff == key_ff);

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      found_in    = found_ff;
      has_free_in = has_free_ff;
      addr_we     = 1'b0;
      drop_we     = 1'b0;
      wr_idx      = hit_ff;
      drop_wdata  = rd_drop_ff + 64'd1;
      valid_we    = 1'b0;
      valid_wdata = 1'b0;
      valid_widx  = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            found_in = 1'b0;
            has_free_in = 1'b0;
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // one read issued per cycle, its registered result checked in the cycle after
            state_in = ST_CHECK;
            scan_in  = scan_ff + CntW'(1);
         end
         ST_CHECK: begin
            if (!found_in && match) begin
               found_in = 1'b1;
               hit_in   = chk_ff;
            end
            if (!has_free_ff && !chk_valid_ff) begin
               has_free_in = 1'b1;
               free_in     = chk_ff;
            end
            if (32'(chk_ff) == Last || (found_ff || match)) begin
               state_in = ST_FETCH;
            end else begin
               scan_in = scan_ff + CntW'(1);
            end
         end
         ST_FETCH: state_in = ST_WRITE;   // counter read of hit entry
         ST_WRITE: state_in = ST_IDLE;
         ST_CLEAR: begin
            // one entry invalidated per cycle after reset
            scan_in = scan_ff + CntW'(1);
            if (32'(scan_ff[IdxW-1:0]) == Last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_CLEAR) begin
         valid_we    = 1'b1;
         valid_wdata = 1'b0;
         valid_widx  = scan_ff[IdxW-1:0];
      end
      if (state_ff == ST_WRITE) begin
         if (kind_ff == KIND_FRAME) begin
            drop_we = found_ff && !exempt_ff && !skip_ff;
         end else if (kind_ff == KIND_ADD) begin
            wr_idx      = found_ff ? hit_ff : free_ff;
            addr_we     = found_ff || has_free_ff;
            drop_we     = addr_we;
            drop_wdata  = '0;
            valid_we    = addr_we;
            valid_wdata = 1'b1;
            valid_widx  = wr_idx;
         end else if (kind_ff == KIND_REMOVE) begin
            valid_we    = found_ff;
            valid_wdata = 1'b0;
            valid_widx  = hit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         kind_ff   <= kind;
         key_ff    <= (kind == KIND_FRAME) ? info.source : address;
         exempt_ff <= info.exempt;
         skip_ff   <= (kind == KIND_FRAME) && !info.ipv4_ok;
      end
      verdict_ff <= '0;
      status_ff  <= STATUS_OK;
      total_ff   <= '0;
      if (state_ff == ST_WRITE) begin
         unique case (kind_ff)
            KIND_FRAME:  verdict_ff <= found_ff && !exempt_ff && !skip_ff;
            KIND_ADD:    status_ff  <= (found_ff || has_free_ff) ? STATUS_OK : STATUS_FULL;
            KIND_REMOVE: status_ff  <= found_ff ? STATUS_OK : STATUS_NOTFOUND;
            KIND_READ: begin
               status_ff <= found_ff ? STATUS_OK : STATUS_NOTFOUND;
               total_ff  <= found_ff ? rd_drop_ff : 64'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         done_ff     <= 1'b0;
         scan_ff     <= '0;
         hit_ff      <= '0;
         free_ff     <= '0;
         found_ff    <= 1'b0;
         has_free_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         hit_ff      <= hit_in;
         free_ff     <= free_in;
         found_ff    <= found_in;
         has_free_ff <= has_free_in;
         done_ff     <= (state_ff == ST_WRITE);
      end
   end

   assign busy       = (state_ff != ST_IDLE) || done_ff;
   assign done       = done_ff;
   assign verdict    = verdict_ff;
   assign status     = status_ff;
   assign drop_total = total_ff;

   a_done_after_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> done_ff) else $error("done not raised");
   a_verdict_frame: assert property (@(posedge clock) disable iff (reset)
      (done_ff && verdict_ff) |-> (kind_ff == KIND_FRAME)) else $error("bad verdict");
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy) else $error("lookup during clear");

endmodule

/* design/ipv4_source_blocklist_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_source_blocklist_filter_unit
// ipv4 source address blocklist filter with drop counters
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries frame bytes (kind 0) and table items (add, remove,
//   read count). rsp_ channel returns one result per table item and per
//   last frame byte. csr_ port writes bypass_enable (0) and bypass_port (1).
// throughput:
//   a frame byte without last mark is never stalled (req_ready stays high)
//   a last byte or a table item starts a linear scan of the address memory,
//   one entry per cycle; a hit stops it early, a miss runs to the last entry;
//   no new lookup item is taken while a scan is in progress
// result path:
//   after the last check the engine steps through ST_FETCH and ST_WRITE,
//   then done is registered, then rsp_valid
// reset:
//   synchronous; parser at frame start; a clearing pass over all entries
//   then marks them invalid (set empty), lookups wait for it
// stall:
//   a waiting result blocks the next item needing a lookup; plain bytes
//   still flow while the result waits
// ----------------------------------------------------------------------------
module ipv4_source_blocklist_filter_unit
   import ipv4bl_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault,
   parameter int MAX_TAGS      = MaxTagsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_verdict,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_drop_total,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic        bypass_enable_ff;
   logic [15:0] bypass_port_ff;
   frame_info_type info;
   logic busy, done, verdict;
   logic [1:0] status;
   logic [63:0] total;
   logic needs_lookup, accept;
   logic rsp_valid_ff;
   logic [1:0] rsp_kind_ff, pend_kind_ff;
   logic rsp_verdict_ff;
   logic [1:0] rsp_status_ff;
   logic [63:0] rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_enable_ff <= 1'b1;
         bypass_port_ff   <= BYPASS_PORT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BYPASS_ENABLE: bypass_enable_ff <= csr_data[0];
            CSR_BYPASS_PORT:   bypass_port_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // items that need a lookup wait until the engine and output are free
   assign needs_lookup = (req_kind != KIND_FRAME) || req_last_byte;
   assign req_ready    = !needs_lookup || (!busy && !rsp_valid_ff);
   assign accept       = req_valid && req_ready;

   ipv4bl_parser #(.MAX_TAGS(MAX_TAGS)) u_parser (
      .clock(clock), .reset(reset),
      .take(accept && req_kind == KIND_FRAME),
      .data_byte(req_data_byte), .last_byte(req_last_byte),
      .bypass_enable(bypass_enable_ff), .bypass_port(bypass_port_ff),
      .info(info));

   ipv4bl_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
      .clock(clock), .reset(reset),
      .start(accept && needs_lookup), .kind(req_kind), .address(req_address),
      .info(info), .busy(busy), .done(done), .verdict(verdict),
      .status(status), .drop_total(total));

   always_ff @(posedge clock) begin
      if (accept && needs_lookup) pend_kind_ff <= req_kind;
      if (done) begin
         rsp_kind_ff    <= pend_kind_ff;
         rsp_verdict_ff <= verdict;
         rsp_status_ff  <= status;
         rsp_total_ff   <= total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_drop_total  = rsp_total_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff) else $error("result overrun");
   a_lookup_blocked: assert property (@(posedge clock) disable iff (reset)
      (busy && req_valid && needs_lookup) |-> !req_ready) else $error("lookup while busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_total_ff)))
      else $error("result lost");

endmodule
